// ----- hw/rtl/sm4cbc_pkg.sv -----
// Shared types, constants and SM4 table functions for the SM4 CBC cipher.
`timescale 1ns / 1ps
`default_nettype none

package sm4cbc_pkg;

    localparam int ROUND_COUNT_DEF = 32;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t REG_KEY_UPPER = 3'd0;
    localparam cfg_index_t REG_KEY_LOWER = 3'd1;
    localparam cfg_index_t REG_IV_UPPER  = 3'd2;
    localparam cfg_index_t REG_IV_LOWER  = 3'd3;
    localparam cfg_index_t REG_DIRECTION = 3'd4;

    typedef struct packed {
        logic [63:0] block_upper;
        logic [63:0] block_lower;
        logic        restart;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_upper;
        logic [63:0] result_lower;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic round_step;
        logic key_step;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_wr;
    } dp_status_t;

    localparam logic [31:0] FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // Byte-wise S-box substitution of a word.
    function automatic logic [31:0] tau(input logic [31:0] w);
        logic [31:0] r;
        for (int b = 0; b < 4; b++)
        begin
            r[8*b +: 8] = SBOX[w[8*b +: 8]];
        end
        return r;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
        return (w << n) | (w >> (32 - n));
    endfunction

    // Key schedule constant: byte j of round i is (4*i + j) * 7 modulo 256.
    function automatic logic [31:0] ck_word(input logic [7:0] i);
        logic [31:0] w;
        logic [7:0]  b;
        for (int j = 0; j < 4; j++)
        begin
            b = (i * 8'd28) + 8'(j * 7);
            w[31 - 8*j -: 8] = b;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sm4cbc_datapath.sv -----
// Datapath of the SM4 CBC cipher: registers, shared round unit, key schedule and key memory.
`timescale 1ns / 1ps
`default_nettype none

module sm4cbc_datapath #(
    parameter int ROUND_COUNT = sm4cbc_pkg::ROUND_COUNT_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  sm4cbc_pkg::cfg_index_t              cfg_index,
    input  wire [63:0]                          cfg_data,
    input  sm4cbc_pkg::in_item_t                blk_data,
    input  sm4cbc_pkg::dp_cmd_t                 cmd,
    input  wire [$clog2(ROUND_COUNT)-1:0]       rd_idx,
    input  wire [$clog2(ROUND_COUNT)-1:0]       wr_idx,
    output sm4cbc_pkg::dp_status_t              status,
    output sm4cbc_pkg::out_item_t               res_data
);
    import sm4cbc_pkg::*;

    localparam int RND_W = $clog2(ROUND_COUNT);

    logic [127:0] key_reg, key_next;
    logic [127:0] iv_reg, iv_next;
    logic         dir_reg, dir_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] cin_reg, cin_next;
    logic [127:0] out_reg, out_next;
    logic [31:0]  x_reg [4];
    logic [31:0]  x_next [4];
    logic [31:0]  k_reg [4];
    logic [31:0]  k_next [4];
    logic [31:0]  rk_reg;
    logic [31:0]  rk_mem [ROUND_COUNT];

    logic [127:0] blk_word;
    logic [127:0] chain_src;
    logic [127:0] x_load;
    logic [127:0] key_new;
    logic [127:0] final_word;
    logic [127:0] cipher_out;
    logic [31:0]  tau_in;
    logic [31:0]  tau_out;
    logic [31:0]  new_key;
    logic [31:0]  new_x;
    logic [RND_W-1:0] rd_addr;
    logic         key_wr;

    assign blk_word = {blk_data.block_upper, blk_data.block_lower};
    assign key_wr   = cfg_wr_en && (cfg_index == REG_KEY_UPPER || cfg_index == REG_KEY_LOWER);
    assign status.key_wr = key_wr;

    // Key pair as it stands after the write in progress.
    assign key_new = (cfg_index == REG_KEY_UPPER) ? {cfg_data, key_reg[63:0]}
                                                  : {key_reg[127:64], cfg_data};

    assign chain_src = blk_data.restart ? iv_reg : chain_reg;
    assign x_load    = dir_reg ? blk_word : (blk_word ^ chain_src);

    // The S-box layer is shared: key expansion and block rounds never overlap.
    assign tau_in  = cmd.key_step
                     ? (k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ ck_word(8'(wr_idx)))
                     : (x_reg[1] ^ x_reg[2] ^ x_reg[3] ^ rk_reg);
    assign tau_out = tau(tau_in);
    assign new_key = k_reg[0] ^ tau_out ^ rotl(tau_out, 13) ^ rotl(tau_out, 23);
    assign new_x   = x_reg[0] ^ tau_out ^ rotl(tau_out, 2) ^ rotl(tau_out, 10)
                     ^ rotl(tau_out, 18) ^ rotl(tau_out, 24);

    assign final_word = {x_reg[3], x_reg[2], x_reg[1], x_reg[0]};
    assign cipher_out = dir_reg ? (final_word ^ chain_reg) : final_word;

    // Decryption walks the round keys from the top down.
    assign rd_addr = dir_reg ? (RND_W'(ROUND_COUNT - 1) - rd_idx) : rd_idx;

    always_comb
    begin
        key_next   = key_reg;
        iv_next    = iv_reg;
        dir_next   = dir_reg;
        chain_next = chain_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KEY_UPPER, REG_KEY_LOWER: key_next = key_new;
                REG_IV_UPPER:  iv_next  = {cfg_data, iv_reg[63:0]};
                REG_IV_LOWER:  iv_next  = {iv_reg[127:64], cfg_data};
                REG_DIRECTION: dir_next = cfg_data[0];
                default:       ;
            endcase
        end
        priority if (cmd.load && blk_data.restart)
        begin
            chain_next = iv_reg;
        end
        else if (cmd.out_load)
        begin
            chain_next = dir_reg ? cin_reg : final_word;
        end
        else
        begin
            chain_next = chain_reg;
        end
    end

    always_comb
    begin
        cin_next = cmd.load ? blk_word : cin_reg;
        out_next = cmd.out_load ? cipher_out : out_reg;
        x_next   = x_reg;
        k_next   = k_reg;
        priority if (cmd.load)
        begin
            x_next[0] = x_load[127:96];
            x_next[1] = x_load[95:64];
            x_next[2] = x_load[63:32];
            x_next[3] = x_load[31:0];
        end
        else if (cmd.round_step)
        begin
            x_next[0] = x_reg[1];
            x_next[1] = x_reg[2];
            x_next[2] = x_reg[3];
            x_next[3] = new_x;
        end
        else
        begin
            x_next = x_reg;
        end
        priority if (key_wr)
        begin
            k_next[0] = key_new[127:96] ^ FK[0];
            k_next[1] = key_new[95:64]  ^ FK[1];
            k_next[2] = key_new[63:32]  ^ FK[2];
            k_next[3] = key_new[31:0]   ^ FK[3];
        end
        else if (cmd.key_step)
        begin
            k_next[0] = k_reg[1];
            k_next[1] = k_reg[2];
            k_next[2] = k_reg[3];
            k_next[3] = new_key;
        end
        else
        begin
            k_next = k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            iv_reg    <= '0;
            dir_reg   <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            key_reg   <= key_next;
            iv_reg    <= iv_next;
            dir_reg   <= dir_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cin_reg <= cin_next;
        out_reg <= out_next;
        x_reg   <= x_next;
        k_reg   <= k_next;
    end

    // Round key memory: one write per expansion step, one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.key_step)
        begin
            rk_mem[wr_idx] <= new_key;
        end
        rk_reg <= rk_mem[rd_addr];
    end

    assign res_data.result_upper = out_reg[127:64];
    assign res_data.result_lower = out_reg[63:0];

endmodule

`default_nettype wire

// ----- hw/rtl/sm4cbc_ctrl.sv -----
// Controller of the SM4 CBC cipher: sequences key expansion, rounds and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module sm4cbc_ctrl #(
    parameter int ROUND_COUNT = sm4cbc_pkg::ROUND_COUNT_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  wire                                 blk_valid,
    output logic                                blk_stall,
    output logic                                res_valid,
    input  wire                                 res_stall,
    input  sm4cbc_pkg::dp_status_t              status,
    output sm4cbc_pkg::dp_cmd_t                 cmd,
    output logic [$clog2(ROUND_COUNT)-1:0]      rd_idx,
    output logic [$clog2(ROUND_COUNT)-1:0]      wr_idx
);
    import sm4cbc_pkg::*;

    localparam int RND_W = $clog2(ROUND_COUNT);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ROUND  = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_EXPAND = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [RND_W-1:0] cnt_reg, cnt_next;
    logic             res_valid_reg, res_valid_next;
    logic             accept;
    logic             out_free;
    logic             last;

    // No block is taken while a register write is on the port.
    assign blk_stall = (state_reg != ST_IDLE) || cfg_wr_en;
    assign accept    = blk_valid && !blk_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign last      = (cnt_reg == RND_W'(ROUND_COUNT - 1));

    assign cmd.load       = accept;
    assign cmd.round_step = (state_reg == ST_ROUND);
    assign cmd.key_step   = (state_reg == ST_EXPAND);
    assign cmd.out_load   = (state_reg == ST_FINISH) && out_free;

    // The key memory read is registered, so the address runs one round ahead.
    assign rd_idx = (state_reg == ST_IDLE) ? '0 : RND_W'(cnt_reg + 1'b1);
    assign wr_idx = cnt_reg;

    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                end
            end
            ST_ROUND:
            begin
                cnt_next = RND_W'(cnt_reg + 1'b1);
                if (last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXPAND:
            begin
                cnt_next = RND_W'(cnt_reg + 1'b1);
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // A key write restarts the expansion from the first round key.
        if (status.key_wr)
        begin
            state_next = ST_EXPAND;
            cnt_next   = '0;
        end
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    a_accept_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ROUND) && (cnt_reg == '0))
        else $error("accepted block did not start at round zero");

    a_last_round_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && last && !status.key_wr |=> (state_reg == ST_FINISH))
        else $error("last round did not lead to the finish step");

    a_key_write_expands: assert property (@(posedge clk) disable iff (!rst_n)
        status.key_wr |=> (state_reg == ST_EXPAND) && (cnt_reg == '0))
        else $error("key write did not restart the expansion");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!res_valid_reg || !res_stall))
        else $error("result register loaded while a stalled result waits");

endmodule

`default_nettype wire

// ----- hw/rtl/sm4_cbc_block_cipher.sv -----
// Top level of the SM4 CBC block cipher: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// SM4 in CBC mode with a 128-bit key. Writing either key register expands the
// round keys with one key schedule step per cycle, so after a key write blocks
// stall until the expansion is done; a block sent before the first key write
// gives an undefined result. Each block transfer is followed by ROUND_COUNT
// rounds on a single shared round unit, fed from a round key memory with a
// registered read, and a finishing step that updates the chain, applies the
// chaining value when decrypting and loads the output register once it is
// free. The next block is taken only after that step, and the result register
// holds its block until the far side takes it.
// Set restart on the first block of a message to start the chain from the IV.
module sm4_cbc_block_cipher #(
    parameter int ROUND_COUNT = sm4cbc_pkg::ROUND_COUNT_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_wr_en,
    input  sm4cbc_pkg::cfg_index_t  cfg_index,
    input  wire [63:0]              cfg_data,
    input  wire                     blk_valid,
    output logic                    blk_stall,
    input  sm4cbc_pkg::in_item_t    blk_data,
    output logic                    res_valid,
    input  wire                     res_stall,
    output sm4cbc_pkg::out_item_t   res_data
);
    import sm4cbc_pkg::*;

    localparam int RND_W = $clog2(ROUND_COUNT);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [RND_W-1:0] rd_idx;
    logic [RND_W-1:0] wr_idx;

    sm4cbc_ctrl #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd),
        .rd_idx    (rd_idx),
        .wr_idx    (wr_idx)
    );

    sm4cbc_datapath #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .blk_data  (blk_data),
        .cmd       (cmd),
        .rd_idx    (rd_idx),
        .wr_idx    (wr_idx),
        .status    (status),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/sm4_cbc_block_cipher_test.sv -----
// Self-checking testbench for the SM4 CBC block cipher with its own cipher predictor.
`timescale 1ns / 1ps

module sm4_cbc_block_cipher_test;

    import sm4cbc_pkg::*;

    localparam int ROUNDS       = ROUND_COUNT_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1720;
    localparam int HOLD_LEN     = 400;
    localparam int SETTLE       = ROUNDS + 8;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       cfg_wr_en  = 1'b0;
    cfg_index_t cfg_index  = REG_KEY_UPPER;
    logic [63:0] cfg_data  = '0;
    logic       blk_valid  = 1'b0;
    logic       blk_stall;
    in_item_t   blk_data   = '0;
    logic       res_valid;
    logic       res_stall  = 1'b0;
    out_item_t  res_data;

    sm4_cbc_block_cipher #(.ROUND_COUNT(ROUNDS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk_data  (blk_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Predictor state: a private copy of the registers, chain and key schedule.
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic        dir_decrypt;
    logic [127:0] chain;
    logic [31:0] round_key [ROUNDS];

    out_item_t expected_blocks [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        sender_idle_en = 1'b1;
    bit        receiver_idle_en = 1'b1;
    int        hold_requests = 0;

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        logic [31:0] r;
        for (int b = 0; b < 4; b++)
        begin
            r[8*b +: 8] = SBOX[w[8*b +: 8]];
        end
        return r;
    endfunction

    function automatic logic [31:0] rot_left(logic [31:0] w, int n);
        logic [63:0] d;
        d = {w, w};
        return d[63-n -: 32];
    endfunction

    function automatic logic [31:0] lin_data(logic [31:0] c);
        return c ^ rot_left(c, 2) ^ rot_left(c, 10) ^ rot_left(c, 18) ^ rot_left(c, 24);
    endfunction

    function automatic logic [31:0] lin_key(logic [31:0] c);
        return c ^ rot_left(c, 13) ^ rot_left(c, 23);
    endfunction

    function automatic logic [31:0] ck_const(int i);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            w = {w[23:0], 8'(((4 * i + j) * 7) & 255)};
        end
        return w;
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] nk;
        k[0] = key_hi[63:32] ^ FK[0];
        k[1] = key_hi[31:0]  ^ FK[1];
        k[2] = key_lo[63:32] ^ FK[2];
        k[3] = key_lo[31:0]  ^ FK[3];
        for (int i = 0; i < ROUNDS; i++)
        begin
            nk = k[i % 4] ^ lin_key(sbox_word(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^
                                              k[(i + 3) % 4] ^ ck_const(i)));
            k[i % 4] = nk;
            round_key[i] = nk;
        end
    endfunction

    function automatic logic [127:0] cipher_rounds(logic [127:0] blk, logic reverse_keys);
        logic [31:0] x [4];
        logic [31:0] rk, t;
        x[0] = blk[127:96];
        x[1] = blk[95:64];
        x[2] = blk[63:32];
        x[3] = blk[31:0];
        for (int i = 0; i < ROUNDS; i++)
        begin
            rk = reverse_keys ? round_key[ROUNDS - 1 - i] : round_key[i];
            t = x[0] ^ lin_data(sbox_word(x[1] ^ x[2] ^ x[3] ^ rk));
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = t;
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    // Computes the cipher output of one block and advances the chain.
    function automatic out_item_t sm4_cbc_predict(in_item_t it);
        logic [127:0] blk, r;
        out_item_t    o;
        blk = {it.block_upper, it.block_lower};
        if (it.restart)
        begin
            chain = {iv_hi, iv_lo};
        end
        if (!dir_decrypt)
        begin
            r = cipher_rounds(blk ^ chain, 1'b0);
            chain = r;
        end
        else
        begin
            r = cipher_rounds(blk, 1'b1) ^ chain;
            chain = blk;
        end
        o.result_upper = r[127:64];
        o.result_lower = r[63:0];
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // Cycle counter with a hard stop.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: checks each transfer and drives random stalls and long hold-offs.
    int stall_left = 0;
    int hold_served = 0;
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none actual %h %h", $time,
                             res_data.result_upper, res_data.result_lower);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (res_data.result_upper !== want.result_upper)
                    begin
                        mismatch_count++;
                        $display("%0t: result_upper mismatch, expected %h actual %h", $time,
                                 want.result_upper, res_data.result_upper);
                    end
                    if (res_data.result_lower !== want.result_lower)
                    begin
                        mismatch_count++;
                        $display("%0t: result_lower mismatch, expected %h actual %h", $time,
                                 want.result_lower, res_data.result_lower);
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                stall_left = HOLD_LEN;
            end
            else if (stall_left == 0 && receiver_idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 4);
            end
            res_stall <= (stall_left > 0);
            if (stall_left > 0)
            begin
                stall_left--;
            end
        end
    end

    // Offers one block and waits for its transfer; valid stays high for the next block.
    task automatic send_block(in_item_t it);
        int gap;
        gap = sender_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            blk_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blk_valid <= 1'b1;
        blk_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (blk_stall);
        expected_blocks.push_back(sm4_cbc_predict(it));
    endtask

    task automatic send_words(logic [63:0] hi, logic [63:0] lo, logic restart);
        in_item_t it;
        it.block_upper = hi;
        it.block_lower = lo;
        it.restart     = restart;
        send_block(it);
    endtask

    // Stops offering blocks and waits until every expected result has arrived.
    task automatic wait_idle();
        blk_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_blocks.size() != 0);
    endtask

    // The pause before each write also covers a key expansion still running.
    task automatic cfg_write(cfg_index_t idx, logic [63:0] value);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        unique case (idx)
            REG_KEY_UPPER:
            begin
                key_hi = value;
                expand_round_keys();
            end
            REG_KEY_LOWER:
            begin
                key_lo = value;
                expand_round_keys();
            end
            REG_IV_UPPER:  iv_hi = value;
            REG_IV_LOWER:  iv_lo = value;
            REG_DIRECTION: dir_decrypt = value[0];
            default: ;
        endcase
    endtask

    // Standard SM4 example: with a zero chain the first ciphertext is the published one.
    task automatic test_reference_vector();
        cfg_write(REG_IV_UPPER, rand64());
        cfg_write(REG_IV_LOWER, rand64());
        cfg_write(REG_KEY_UPPER, 64'h0123456789abcdef);
        cfg_write(REG_KEY_LOWER, 64'hfedcba9876543210);
        cfg_write(REG_DIRECTION, 64'd0);
        // No restart on the first block after reset: the chain is still zero.
        send_words(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        send_words(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
        send_words(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        wait_idle();
        cfg_write(REG_DIRECTION, 64'd1);
        send_words(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b1);
        send_words(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        send_words('0, '0, 1'b1);
        send_words('1, '1, 1'b0);
        send_words(64'h8000000000000000, 64'h0000000000000001, 1'b1);
        send_words(64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 1'b0);
        wait_idle();
        cfg_write(REG_DIRECTION, 64'd0);
        send_words('1, '0, 1'b1);
        send_words('0, '1, 1'b0);
        wait_idle();
    endtask

    // Register changes inside a message keep the chain; a new IV waits for a restart.
    task automatic test_config_in_message();
        send_words(rand64(), rand64(), 1'b1);
        wait_idle();
        cfg_write(REG_IV_UPPER, '1);
        cfg_write(REG_IV_LOWER, '1);
        send_words(rand64(), rand64(), 1'b0);
        send_words(rand64(), rand64(), 1'b1);
        wait_idle();
        cfg_write(REG_DIRECTION, 64'd1);
        send_words(rand64(), rand64(), 1'b0);
        wait_idle();
        cfg_write(REG_KEY_UPPER, rand64());
        send_words(rand64(), rand64(), 1'b0);
        wait_idle();
        for (int k = REG_DIRECTION + 1; k < (1 << $bits(cfg_index_t)); k++)
        begin
            cfg_write(cfg_index_t'(k), '1);
        end
        send_words(rand64(), rand64(), 1'b0);
        wait_idle();
    endtask

    // Receiver holds off long enough for the block to fill up and stall its input.
    task automatic test_backpressure();
        sender_idle_en = 1'b0;
        hold_requests++;
        for (int i = 0; i < 8; i++)
        begin
            send_words(rand64(), rand64(), (i == 0));
        end
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            send_words(rand64(), rand64(), 1'b0);
        end
        wait_idle();
        sender_idle_en = 1'b1;
    endtask

    task automatic test_random_messages();
        int sent;
        int phase;
        int phase_end;
        int msg_len;
        bit noise;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            unique case (phase)
                0:
                begin
                    cfg_write(REG_KEY_UPPER, '0);
                    cfg_write(REG_KEY_LOWER, '0);
                    cfg_write(REG_IV_UPPER, '0);
                    cfg_write(REG_IV_LOWER, '0);
                end
                1:
                begin
                    cfg_write(REG_KEY_UPPER, '1);
                    cfg_write(REG_KEY_LOWER, '1);
                    cfg_write(REG_IV_UPPER, '1);
                    cfg_write(REG_IV_LOWER, '1);
                end
                default:
                begin
                    cfg_write(REG_KEY_UPPER, rand64());
                    cfg_write(REG_KEY_LOWER, rand64());
                    cfg_write(REG_IV_UPPER, rand64());
                    cfg_write(REG_IV_LOWER, rand64());
                end
            endcase
            cfg_write(REG_DIRECTION, {rand64()} >> 1 << 1 | 64'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
            begin
                sender_idle_en = 1'b0;
                receiver_idle_en = 1'b0;
            end
            else
            begin
                sender_idle_en = $urandom_range(0, 3) != 0;
                receiver_idle_en = $urandom_range(0, 3) != 0;
            end
            phase_end = sent + $urandom_range(60, 140);
            while (sent < phase_end && sent < RANDOM_ITEMS)
            begin
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
                noise = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < msg_len; i++)
                begin
                    send_words(rand64(), rand64(),
                               noise ? 1'($urandom_range(0, 1)) : (i == 0));
                    sent++;
                end
                if ($urandom_range(0, 15) == 0)
                begin
                    wait_idle();
                end
            end
            phase++;
        end
        sender_idle_en = 1'b1;
        receiver_idle_en = 1'b1;
    endtask

    initial
    begin
        key_hi = '0;
        key_lo = '0;
        iv_hi = '0;
        iv_lo = '0;
        dir_decrypt = 1'b0;
        chain = '0;
        for (int i = 0; i < ROUNDS; i++)
        begin
            round_key[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reference_vector();
        test_field_extremes();
        test_config_in_message();
        test_backpressure();
        test_random_messages();

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
